// File: hdl/ddfl_pkg.sv
// ----------------------------------------------------------------------------
// ddfl_pkg
// Shared types, constants and fixed-point helpers for the differential-drive
// feedback linearization core.
// ----------------------------------------------------------------------------
package ddfl_pkg;

    localparam int FRAC_BITS = 16;
    localparam int Q30_SHIFT = 30 - FRAC_BITS;
    localparam int CORD_W    = 48;
    localparam int ATAN_N    = 24;
    localparam int CNT_W     = 5;
    localparam int DIV_W     = 33 + FRAC_BITS;

    localparam logic signed [CORD_W-1:0] Q30_PI      = 48'sd3373259426;
    localparam logic signed [CORD_W-1:0] Q30_HALF_PI = 48'sd1686629713;
    localparam logic signed [CORD_W-1:0] Q30_GAIN    = 48'sd652032874;

    localparam logic [2:0] REG_GAIN_X       = 3'd0;
    localparam logic [2:0] REG_GAIN_Y       = 3'd1;
    localparam logic [2:0] REG_POINT_OFFSET = 3'd2;
    localparam logic [2:0] REG_WHEEL_TRACK  = 3'd3;
    localparam logic [2:0] REG_WHEEL_RADIUS = 3'd4;
    localparam logic [2:0] REG_MIN_INTERVAL = 3'd5;

    typedef enum logic [1:0] {CS_IDLE, CS_PREP, CS_RUN, CS_DONE} t_cord_state;
    typedef enum logic [1:0] {DS_IDLE, DS_RUN, DS_DONE} t_div_state;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RY_GO, ST_RY_WAIT, ST_RYD_GO, ST_RYD_WAIT, ST_SCR_GO, ST_SCR_WAIT,
        ST_FX_GO, ST_FX_M1, ST_FX_WAIT, ST_FY_GO, ST_FY_M1, ST_FY_WAIT,
        ST_TH_GO, ST_TH_WAIT, ST_SC_GO, ST_SC_WAIT, ST_EX, ST_EY, ST_VY,
        ST_N0, ST_N1, ST_N2, ST_N3, ST_N4, ST_W_WAIT, ST_H0, ST_H1,
        ST_L_GO, ST_L_WAIT, ST_R_GO, ST_R_WAIT
    } t_state;

    typedef struct packed {
        logic               start;
        logic               vec;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic signed [31:0] ang;
    } t_cord_req;

    typedef struct packed {
        logic               start;
        logic signed [32:0] num;
        logic [30:0]        den;
    } t_div_req;

    function automatic logic signed [CORD_W-1:0] f_atan(input logic [CNT_W-1:0] idx);
        logic signed [CORD_W-1:0] r;
        case (idx)
            5'd0:  r = 48'sd843314857;
            5'd1:  r = 48'sd497837829;
            5'd2:  r = 48'sd263043837;
            5'd3:  r = 48'sd133525159;
            5'd4:  r = 48'sd67021687;
            5'd5:  r = 48'sd33543516;
            5'd6:  r = 48'sd16775851;
            5'd7:  r = 48'sd8388437;
            5'd8:  r = 48'sd4194283;
            5'd9:  r = 48'sd2097149;
            5'd10: r = 48'sd1048576;
            5'd11: r = 48'sd524288;
            5'd12: r = 48'sd262144;
            5'd13: r = 48'sd131072;
            5'd14: r = 48'sd65536;
            5'd15: r = 48'sd32768;
            5'd16: r = 48'sd16384;
            5'd17: r = 48'sd8192;
            5'd18: r = 48'sd4096;
            5'd19: r = 48'sd2048;
            5'd20: r = 48'sd1024;
            5'd21: r = 48'sd512;
            5'd22: r = 48'sd256;
            5'd23: r = 48'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -68'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // round half up, drop FRAC_BITS
    function automatic logic signed [31:0] f_mulq(input logic signed [65:0] p);
        logic signed [67:0] t;
        t = 68'(p) + (68'sd1 <<< (FRAC_BITS - 1));
        return f_sat32(t >>> FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] f_half(input logic signed [65:0] p);
        logic signed [67:0] t;
        t = 68'(p) + (68'sd1 <<< FRAC_BITS);
        return f_sat32(t >>> (FRAC_BITS + 1));
    endfunction

    function automatic logic signed [31:0] f_q30(input logic signed [CORD_W-1:0] v);
        logic signed [67:0] t;
        t = 68'(v) + (68'sd1 <<< (Q30_SHIFT - 1));
        return f_sat32(t >>> Q30_SHIFT);
    endfunction

endpackage

// File: hdl/ddfl_cordic.sv
// ----------------------------------------------------------------------------
// ddfl_cordic
// Iterative CORDIC: vectoring mode gives yaw from a planar quaternion,
// rotation mode gives sine and cosine of an angle. One step per cycle.
// ----------------------------------------------------------------------------
module ddfl_cordic
    import ddfl_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cord_req          i_req,
    output logic               o_done,
    output logic signed [31:0] o_ang,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);

    localparam int N = (CORDIC_STEPS > ATAN_N) ? ATAN_N : CORDIC_STEPS;

    t_cord_state r_state, n_state;
    logic signed [CORD_W-1:0] r_x, r_y, r_z;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_vec, r_neg, r_zero;

    logic signed [31:0]       sq_w, sq_z, p_zw;
    logic signed [CORD_W-1:0] dx, dy, at;
    logic                     dir;

    assign sq_w = i_req.qw * i_req.qw;
    assign sq_z = i_req.qz * i_req.qz;
    assign p_zw = i_req.qz * i_req.qw;
    assign dx   = r_y >>> r_cnt;
    assign dy   = r_x >>> r_cnt;
    assign at   = f_atan(r_cnt);
    assign dir  = r_vec ? (r_y < 0) : (r_z >= 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= CS_IDLE;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_IDLE: if (i_req.start) n_state = CS_PREP;
            CS_PREP: n_state = CS_RUN;
            CS_RUN:  if (r_cnt == CNT_W'(N - 1)) n_state = CS_DONE;
            CS_DONE: n_state = CS_IDLE;
            default: n_state = CS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            CS_IDLE: begin
                r_cnt  <= '0;
                r_neg  <= 1'b0;
                r_zero <= 1'b0;
                r_vec  <= i_req.vec;
                if (i_req.vec) begin
                    r_x <= CORD_W'(sq_w) - CORD_W'(sq_z);
                    r_y <= CORD_W'(p_zw) <<< 1;
                    r_z <= '0;
                end else begin
                    r_x <= Q30_GAIN;
                    r_y <= '0;
                    r_z <= CORD_W'(i_req.ang) <<< Q30_SHIFT;
                end
            end
            CS_PREP: begin
                if (r_vec) begin
                    r_zero <= (r_x == 0) && (r_y == 0);
                    if (r_x < 0) begin
                        r_z <= (r_y >= 0) ? Q30_PI : -Q30_PI;
                        r_x <= -r_x;
                        r_y <= -r_y;
                    end
                end else if (r_z > Q30_HALF_PI) begin
                    r_z   <= r_z - Q30_PI;
                    r_neg <= 1'b1;
                end else if (r_z < -Q30_HALF_PI) begin
                    r_z   <= r_z + Q30_PI;
                    r_neg <= 1'b1;
                end
            end
            CS_RUN: begin
                r_cnt <= r_cnt + 1'b1;
                if (dir) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end
            end
            default: ;
        endcase
    end

    assign o_done = (r_state == CS_DONE);
    assign o_ang  = r_zero ? '0 : f_q30(r_z);
    assign o_sin  = f_q30(r_neg ? -r_y : r_y);
    assign o_cos  = f_q30(r_neg ? -r_x : r_x);

endmodule

// File: hdl/ddfl_div.sv
// ----------------------------------------------------------------------------
// ddfl_div
// Restoring divider: (num << FRAC_BITS) / den, truncated toward zero and
// saturated to 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddfl_div
    import ddfl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    output logic               o_done,
    output logic signed [31:0] o_quo
);

    t_div_state r_state, n_state;
    logic [DIV_W-1:0] r_dvd;
    logic [31:0]      r_rem;
    logic [30:0]      r_den;
    logic [5:0]       r_cnt;
    logic             r_neg;

    logic [33:0]      mag;
    logic [32:0]      rs;
    logic             fits;

    assign mag  = i_req.num[32] ? -34'(i_req.num) : 34'(i_req.num);
    assign rs   = {r_rem, r_dvd[DIV_W-1]};
    assign fits = (rs >= {2'b00, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= DS_IDLE;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DS_IDLE: if (i_req.start) n_state = DS_RUN;
            DS_RUN:  if (r_cnt == 6'd1) n_state = DS_DONE;
            DS_DONE: n_state = DS_IDLE;
            default: n_state = DS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            DS_IDLE: begin
                r_dvd <= {mag[32:0], {FRAC_BITS{1'b0}}};
                r_rem <= '0;
                r_den <= i_req.den;
                r_neg <= i_req.num[32];
                r_cnt <= 6'(DIV_W);
            end
            DS_RUN: begin
                r_cnt <= r_cnt - 1'b1;
                r_rem <= fits ? 32'(rs - {2'b00, r_den}) : rs[31:0];
                r_dvd <= {r_dvd[DIV_W-2:0], fits};
            end
            default: ;
        endcase
    end

    always_comb begin
        if (!r_neg)
            o_quo = (|r_dvd[DIV_W-1:31]) ? 32'sh7FFFFFFF : $signed(r_dvd[31:0]);
        else if (r_dvd > DIV_W'(32'h80000000))
            o_quo = 32'sh80000000;
        else
            o_quo = -$signed(r_dvd[31:0]);
    end

    assign o_done = (r_state == DS_DONE);

endmodule

// File: hdl/diff_drive_feedback_linearization_core.sv
// ----------------------------------------------------------------------------
// diff_drive_feedback_linearization_core
// Unicycle tracking controller: yaw by CORDIC, feed-forward from held reference,
// proportional correction of an external point, feedback linearization.
// Items pass one at a time through the 49-step divider and the shared CORDIC.
// Input ready only in idle; a finished result waits in the output register.
// Reset (synchronous, active low) restores the register defaults and clears
//   the held state; no clearing pass.
// ----------------------------------------------------------------------------
module diff_drive_feedback_linearization_core
    import ddfl_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // ref_pos_x, ref_pos_y, ref_quat_z, ref_quat_w, feed_pos_x, feed_pos_y,
    // feed_quat_z, feed_quat_w, elapsed_time, zero pad
    input  logic [223:0] s_axis_tdata,
    // ref_valid, feed_valid
    input  logic [4:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // left_wheel_rate, right_wheel_rate, body_angular_rate
    output logic [95:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    t_state r_state, n_state;

    logic [22:0] r_gain_x, r_gain_y;
    logic [17:0] r_pofs;
    logic [18:0] r_track;
    logic [16:0] r_rad, r_minint;

    logic signed [31:0] r_held_rx, r_held_ry, r_held_yaw, r_ff_ang;
    logic signed [31:0] r_ff_vx, r_ff_vy, r_held_fx, r_held_fy;

    logic signed [31:0] r_rx, r_ry;
    logic signed [15:0] r_rqz, r_rqw, r_fqz, r_fqw;
    logic [2:0]         r_rv;
    logic [30:0]        r_dt;

    logic signed [31:0] r_t0, r_sf, r_cf, r_s, r_c, r_vpx, r_vpy, r_v, r_w, r_half, r_lw;
    logic signed [65:0] r_prod;

    logic               r_out_valid;
    logic signed [31:0] r_o_l, r_o_r, r_o_w;
    logic               r_rw_ok;
    logic signed [31:0] r_rw;

    logic               in_xfer, out_free, cfg_wr, fin;
    logic signed [31:0] right_q;
    logic [17:0]        pofs_nz;
    logic [16:0]        rad_nz, min_nz;
    logic [30:0]        el;
    logic signed [31:0] mq, ex, ey, num_w;

    logic               mul_en;
    logic signed [32:0] mul_a, mul_b;

    t_cord_req          creq;
    t_div_req           dreq;
    logic               cord_done, div_done;
    logic signed [31:0] cord_ang, cord_sin, cord_cos, div_quo;

    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign fin           = (r_state == ST_R_WAIT) && (div_done || r_rw_ok) && out_free;
    assign right_q       = r_rw_ok ? r_rw : div_quo;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_o_w, r_o_r, r_o_l};

    assign pofs_nz = (r_pofs == '0) ? 18'd1 : r_pofs;
    assign rad_nz  = (r_rad == '0) ? 17'd1 : r_rad;
    assign min_nz  = (r_minint == '0) ? 17'd1 : r_minint;
    assign el      = s_axis_tdata[222:192];

    assign mq    = f_mulq(r_prod);
    assign ex    = f_sat32(68'(r_held_rx) - 68'(r_held_fx));
    assign ey    = f_sat32(68'(r_held_ry) - 68'(r_held_fy));
    assign num_w = f_sat32(68'(r_t0) - 68'(mq));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_x <= 23'd131072;
            r_gain_y <= 23'd131072;
            r_pofs   <= 18'd6554;
            r_track  <= 19'd10486;
            r_rad    <= 17'd2163;
            r_minint <= 17'd6554;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_GAIN_X:       r_gain_x <= pwdata[22:0];
                REG_GAIN_Y:       r_gain_y <= pwdata[22:0];
                REG_POINT_OFFSET: r_pofs   <= pwdata[17:0];
                REG_WHEEL_TRACK:  r_track  <= pwdata[18:0];
                REG_WHEEL_RADIUS: r_rad    <= pwdata[16:0];
                REG_MIN_INTERVAL: r_minint <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_GAIN_X:       prdata = 32'(r_gain_x);
            REG_GAIN_Y:       prdata = 32'(r_gain_y);
            REG_POINT_OFFSET: prdata = 32'(r_pofs);
            REG_WHEEL_TRACK:  prdata = 32'(r_track);
            REG_WHEEL_RADIUS: prdata = 32'(r_rad);
            REG_MIN_INTERVAL: prdata = 32'(r_minint);
            default:          prdata = '0;
        endcase
    end

    ddfl_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (creq),
        .o_done  (cord_done),
        .o_ang   (cord_ang),
        .o_sin   (cord_sin),
        .o_cos   (cord_cos)
    );

    ddfl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dreq),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= ST_IDLE;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state   = r_state;
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        creq      = '0;
        dreq      = '0;
        dreq.den  = r_dt;
        unique case (r_state)
            ST_IDLE: if (in_xfer) n_state = s_axis_tuser[2] ? ST_RY_GO : ST_SCR_GO;
            ST_RY_GO: begin
                creq.start = 1'b1;
                creq.vec   = 1'b1;
                creq.qz    = r_rqz;
                creq.qw    = r_rqw;
                n_state    = ST_RY_WAIT;
            end
            ST_RY_WAIT: if (cord_done) n_state = ST_RYD_GO;
            ST_RYD_GO: begin
                dreq.start = 1'b1;
                dreq.num   = 33'(r_t0) - 33'(r_held_yaw);
                n_state    = ST_RYD_WAIT;
            end
            ST_RYD_WAIT: if (div_done) n_state = ST_SCR_GO;
            ST_SCR_GO: begin
                creq.start = 1'b1;
                creq.ang   = r_held_yaw;
                n_state    = ST_SCR_WAIT;
            end
            ST_SCR_WAIT: begin
                if (cord_done)
                    n_state = r_rv[0] ? ST_FX_GO : (r_rv[1] ? ST_FY_GO : ST_TH_GO);
            end
            ST_FX_GO: begin
                dreq.start = 1'b1;
                dreq.num   = 33'(r_rx) - 33'(r_held_rx);
                mul_en     = 1'b1;
                mul_a      = 33'(pofs_nz);
                mul_b      = 33'(r_sf);
                n_state    = ST_FX_M1;
            end
            ST_FX_M1: begin
                mul_en  = 1'b1;
                mul_a   = 33'(mq);
                mul_b   = 33'(r_ff_ang);
                n_state = ST_FX_WAIT;
            end
            ST_FX_WAIT: if (div_done) n_state = r_rv[1] ? ST_FY_GO : ST_TH_GO;
            ST_FY_GO: begin
                dreq.start = 1'b1;
                dreq.num   = 33'(r_ry) - 33'(r_held_ry);
                mul_en     = 1'b1;
                mul_a      = 33'(pofs_nz);
                mul_b      = 33'(r_cf);
                n_state    = ST_FY_M1;
            end
            ST_FY_M1: begin
                mul_en  = 1'b1;
                mul_a   = 33'(mq);
                mul_b   = 33'(r_ff_ang);
                n_state = ST_FY_WAIT;
            end
            ST_FY_WAIT: if (div_done) n_state = ST_TH_GO;
            ST_TH_GO: begin
                creq.start = 1'b1;
                creq.vec   = 1'b1;
                creq.qz    = r_fqz;
                creq.qw    = r_fqw;
                n_state    = ST_TH_WAIT;
            end
            ST_TH_WAIT: if (cord_done) n_state = ST_SC_GO;
            ST_SC_GO: begin
                creq.start = 1'b1;
                creq.ang   = r_t0;
                n_state    = ST_SC_WAIT;
            end
            ST_SC_WAIT: if (cord_done) n_state = ST_EX;
            ST_EX: begin
                mul_en  = 1'b1;
                mul_a   = 33'(r_gain_x);
                mul_b   = 33'(ex);
                n_state = ST_EY;
            end
            ST_EY: begin
                mul_en  = 1'b1;
                mul_a   = 33'(r_gain_y);
                mul_b   = 33'(ey);
                n_state = ST_VY;
            end
            ST_VY: n_state = ST_N0;
            ST_N0: begin
                mul_en  = 1'b1;
                mul_a   = 33'(r_vpy);
                mul_b   = 33'(r_c);
                n_state = ST_N1;
            end
            ST_N1: begin
                mul_en  = 1'b1;
                mul_a   = 33'(r_vpx);
                mul_b   = 33'(r_s);
                n_state = ST_N2;
            end
            ST_N2: begin
                dreq.start = 1'b1;
                dreq.num   = 33'(num_w);
                dreq.den   = 31'(pofs_nz);
                mul_en     = 1'b1;
                mul_a      = 33'(r_vpx);
                mul_b      = 33'(r_c);
                n_state    = ST_N3;
            end
            ST_N3: begin
                mul_en  = 1'b1;
                mul_a   = 33'(r_vpy);
                mul_b   = 33'(r_s);
                n_state = ST_N4;
            end
            ST_N4: n_state = ST_W_WAIT;
            ST_W_WAIT: if (div_done) n_state = ST_H0;
            ST_H0: begin
                mul_en  = 1'b1;
                mul_a   = 33'(r_w);
                mul_b   = 33'(r_track);
                n_state = ST_H1;
            end
            ST_H1: n_state = ST_L_GO;
            ST_L_GO: begin
                dreq.start = 1'b1;
                dreq.num   = 33'(r_v) - 33'(r_half);
                dreq.den   = 31'(rad_nz);
                n_state    = ST_L_WAIT;
            end
            ST_L_WAIT: if (div_done) n_state = ST_R_GO;
            ST_R_GO: begin
                dreq.start = 1'b1;
                dreq.num   = 33'(r_v) + 33'(r_half);
                dreq.den   = 31'(rad_nz);
                n_state    = ST_R_WAIT;
            end
            ST_R_WAIT: if (fin) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // shared multiplier, product registered
    always_ff @(posedge i_clk) begin
        if (mul_en)
            r_prod <= mul_a * mul_b;
    end

    // held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_rx  <= '0;
            r_held_ry  <= '0;
            r_held_yaw <= '0;
            r_ff_ang   <= '0;
            r_ff_vx    <= '0;
            r_ff_vy    <= '0;
            r_held_fx  <= '0;
            r_held_fy  <= '0;
        end else begin
            if (in_xfer && s_axis_tuser[3]) r_held_fx <= $signed(s_axis_tdata[127:96]);
            if (in_xfer && s_axis_tuser[4]) r_held_fy <= $signed(s_axis_tdata[159:128]);
            if (r_state == ST_RYD_WAIT && div_done) begin
                r_ff_ang   <= div_quo;
                r_held_yaw <= r_t0;
            end
            if (r_state == ST_FX_WAIT && div_done) begin
                r_ff_vx   <= f_sat32(68'(div_quo) - 68'(mq));
                r_held_rx <= r_rx;
            end
            if (r_state == ST_FY_WAIT && div_done) begin
                r_ff_vy   <= f_sat32(68'(div_quo) + 68'(mq));
                r_held_ry <= r_ry;
            end
        end
    end

    // item latch and working registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_rx  <= $signed(s_axis_tdata[31:0]);
            r_ry  <= $signed(s_axis_tdata[63:32]);
            r_rqz <= $signed(s_axis_tdata[79:64]);
            r_rqw <= $signed(s_axis_tdata[95:80]);
            r_fqz <= $signed(s_axis_tdata[175:160]);
            r_fqw <= $signed(s_axis_tdata[191:176]);
            r_rv  <= s_axis_tuser[2:0];
            r_dt  <= (el < 31'(min_nz)) ? 31'(min_nz) : el;
        end
        case (r_state)
            ST_RY_WAIT:  if (cord_done) r_t0 <= cord_ang;
            ST_TH_WAIT:  if (cord_done) r_t0 <= cord_ang;
            ST_SCR_WAIT: begin
                if (cord_done) begin
                    r_sf <= cord_sin;
                    r_cf <= cord_cos;
                end
            end
            ST_SC_WAIT: begin
                if (cord_done) begin
                    r_s <= cord_sin;
                    r_c <= cord_cos;
                end
            end
            ST_EY:     r_vpx  <= f_sat32(68'(r_ff_vx) + 68'(mq));
            ST_VY:     r_vpy  <= f_sat32(68'(r_ff_vy) + 68'(mq));
            ST_N1:     r_t0   <= mq;
            ST_N3:     r_t0   <= mq;
            ST_N4:     r_v    <= f_sat32(68'(r_t0) + 68'(mq));
            ST_W_WAIT: if (div_done) r_w <= div_quo;
            ST_H1:     r_half <= f_half(r_prod);
            ST_L_WAIT: if (div_done) r_lw <= div_quo;
            ST_R_WAIT: if (div_done) r_rw <= div_quo;
            default: ;
        endcase
    end

    // hold the right quotient while the output slot is still busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_rw_ok <= 1'b0;
        else if (fin)
            r_rw_ok <= 1'b0;
        else if (r_state == ST_R_WAIT && div_done)
            r_rw_ok <= 1'b1;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_o_l <= r_lw;
            r_o_r <= right_q;
            r_o_w <= r_w;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> m_axis_tvalid)
        else $error("result not presented after final divide");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cord_done |-> (r_state == ST_RY_WAIT || r_state == ST_SCR_WAIT ||
                       r_state == ST_TH_WAIT || r_state == ST_SC_WAIT))
        else $error("CORDIC finished outside a wait state");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_done && r_state != ST_R_WAIT) |-> (r_state == ST_RYD_WAIT ||
            r_state == ST_FX_WAIT || r_state == ST_FY_WAIT ||
            r_state == ST_W_WAIT || r_state == ST_L_WAIT))
        else $error("divider finished outside a wait state");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the differential-drive feedback linearization core.
// Pose items go in over the slave stream with bursty timing, wheel commands
// come out over the master stream under a changing stall pattern, and every
// result is compared field by field with a fixed-point model of the controller
// kept in this bench. The register set is swept between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import ddfl_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int CORD_N         = 16;

    typedef struct {
        logic signed [31:0] ref_x;
        logic signed [31:0] ref_y;
        logic signed [15:0] ref_qz;
        logic signed [15:0] ref_qw;
        logic [2:0]         ref_ok;
        logic signed [31:0] meas_x;
        logic signed [31:0] meas_y;
        logic signed [15:0] meas_qz;
        logic signed [15:0] meas_qw;
        logic [1:0]         meas_ok;
        logic [30:0]        step_dt;
    } t_pose_item;

    typedef struct {
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic signed [31:0] body;
    } t_wheel_cmd;

    localparam longint ATAN_TBL [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };
    localparam longint PI_Q30      = 64'd3373259426;
    localparam longint HALF_PI_Q30 = 64'd1686629713;
    localparam longint GAIN_Q30    = 64'd652032874;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata;
    logic [4:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    diff_drive_feedback_linearization_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // register shadows, masked to their widths
    longint gain_x_r, gain_y_r, offset_r, track_r, radius_r, min_dt_r;
    // controller state
    int     ref_x_h, ref_y_h, ref_yaw_h, ff_w, ff_vx, ff_vy, meas_x_h, meas_y_h;

    t_wheel_cmd cmd_queue[$];
    int         n_errors;
    int         burst_left;
    int         idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- fixed-point model ----------------
    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic int mul_fx(longint a, longint b);
        return sat32((a * b + 64'sd32768) >>> 16);
    endfunction

    function automatic int div_fx(longint num, longint den);
        return sat32((num * 64'sd65536) / den);
    endfunction

    function automatic int q30_fx(longint v);
        return sat32((v + 64'sd8192) >>> 14);
    endfunction

    function automatic longint at_least_one(longint v);
        return (v == 0) ? 64'sd1 : v;
    endfunction

    function automatic int quat_to_yaw(longint qz, longint qw);
        longint x, y, z, dx, dy;
        y = 2 * qz * qw;
        x = qw * qw - qz * qz;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_Q30 : -PI_Q30;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORD_N; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end
        end
        return q30_fx(z);
    endfunction

    task automatic sine_cosine(input int ang, output int s, output int c);
        longint x, y, z, dx, dy;
        bit     flip;
        z = longint'(ang) * 64'sd16384;
        x = GAIN_Q30;
        y = 0;
        flip = 1'b0;
        if (z > HALF_PI_Q30) begin
            z -= PI_Q30; flip = 1'b1;
        end else if (z < -HALF_PI_Q30) begin
            z += PI_Q30; flip = 1'b1;
        end
        for (int i = 0; i < CORD_N; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        s = q30_fx(y);
        c = q30_fx(x);
    endtask

    task automatic predict_wheel_cmd(input t_pose_item it, output t_wheel_cmd cmd);
        longint dt, pofs, rad;
        int     yaw_new, sf, cf, s, c, th, ex, ey, vpx, vpy, num, w, v, half;
        dt   = longint'(it.step_dt);
        pofs = at_least_one(offset_r);
        rad  = at_least_one(radius_r);
        if (dt < at_least_one(min_dt_r)) dt = at_least_one(min_dt_r);

        if (it.ref_ok[2]) begin
            yaw_new = quat_to_yaw(it.ref_qz, it.ref_qw);
            ff_w = div_fx(longint'(yaw_new) - ref_yaw_h, dt);
            ref_yaw_h = yaw_new;
        end
        sine_cosine(ref_yaw_h, sf, cf);
        if (it.ref_ok[0]) begin
            ff_vx = sat32(longint'(div_fx(longint'(it.ref_x) - ref_x_h, dt))
                          - mul_fx(mul_fx(pofs, sf), ff_w));
            ref_x_h = it.ref_x;
        end
        if (it.ref_ok[1]) begin
            ff_vy = sat32(longint'(div_fx(longint'(it.ref_y) - ref_y_h, dt))
                          + mul_fx(mul_fx(pofs, cf), ff_w));
            ref_y_h = it.ref_y;
        end
        if (it.meas_ok[0]) meas_x_h = it.meas_x;
        if (it.meas_ok[1]) meas_y_h = it.meas_y;

        th = quat_to_yaw(it.meas_qz, it.meas_qw);
        sine_cosine(th, s, c);
        ex   = sat32(longint'(ref_x_h) - meas_x_h);
        ey   = sat32(longint'(ref_y_h) - meas_y_h);
        vpx  = sat32(longint'(ff_vx) + mul_fx(gain_x_r, ex));
        vpy  = sat32(longint'(ff_vy) + mul_fx(gain_y_r, ey));
        num  = sat32(longint'(mul_fx(vpy, c)) - mul_fx(vpx, s));
        w    = div_fx(num, pofs);
        v    = sat32(longint'(mul_fx(vpx, c)) + mul_fx(vpy, s));
        half = sat32((longint'(w) * track_r + 64'sd65536) >>> 17);
        cmd.left  = div_fx(longint'(v) - half, rad);
        cmd.right = div_fx(longint'(v) + half, rad);
        cmd.body  = w;
    endtask

    // ---------------- bus tasks ----------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GAIN_X:       gain_x_r = val & 32'h7FFFFF;
            REG_GAIN_Y:       gain_y_r = val & 32'h7FFFFF;
            REG_POINT_OFFSET: offset_r = val & 32'h3FFFF;
            REG_WHEEL_TRACK:  track_r  = val & 32'h7FFFF;
            REG_WHEEL_RADIUS: radius_r = val & 32'h1FFFF;
            REG_MIN_INTERVAL: min_dt_r = val & 32'h1FFFF;
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [31:0] gx, input logic [31:0] gy,
                                  input logic [31:0] ofs, input logic [31:0] trk,
                                  input logic [31:0] rad, input logic [31:0] mdt);
        write_reg(REG_GAIN_X, gx);
        write_reg(REG_GAIN_Y, gy);
        write_reg(REG_POINT_OFFSET, ofs);
        write_reg(REG_WHEEL_TRACK, trk);
        write_reg(REG_WHEEL_RADIUS, rad);
        write_reg(REG_MIN_INTERVAL, mdt);
    endtask

    // hold until every command is back and the core sits in idle
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (cmd_queue.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic send_pose(input t_pose_item it);
        int         gap;
        t_wheel_cmd cmd;
        if (burst_left == 0) begin
            gap = (($urandom & 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, it.step_dt, it.meas_qw, it.meas_qz, it.meas_y, it.meas_x,
                          it.ref_qw, it.ref_qz, it.ref_y, it.ref_x};
        s_axis_tuser  <= {it.meas_ok, it.ref_ok};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_wheel_cmd(it, cmd);
        cmd_queue.push_back(cmd);
        burst_left--;
    endtask

    // ---------------- stimulus helpers ----------------
    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            default: return $signed($urandom_range(0, 1310720)) - 655360;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_quat();
        case ($urandom_range(0, 2))
            0:       return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic [30:0] rand_dt();
        case ($urandom_range(0, 7))
            0:       return 31'($urandom);
            1:       return 31'($urandom_range(0, 7000));
            default: return 31'($urandom_range(655, 13107));
        endcase
    endfunction

    function automatic t_pose_item rand_pose();
        t_pose_item it;
        it.ref_x   = rand_pos();
        it.ref_y   = rand_pos();
        it.ref_qz  = rand_quat();
        it.ref_qw  = rand_quat();
        it.ref_ok  = ($urandom_range(0, 9) < 7) ? 3'b111 : 3'($urandom);
        it.meas_x  = rand_pos();
        it.meas_y  = rand_pos();
        it.meas_qz = rand_quat();
        it.meas_qw = rand_quat();
        it.meas_ok = ($urandom_range(0, 9) < 7) ? 2'b11 : 2'($urandom);
        it.step_dt = rand_dt();
        return it;
    endfunction

    function automatic t_pose_item make_pose(logic signed [31:0] rx, logic signed [31:0] ry,
                                             logic signed [15:0] rqz, logic signed [15:0] rqw,
                                             logic [2:0] rv, logic signed [31:0] fx,
                                             logic signed [31:0] fy, logic signed [15:0] fqz,
                                             logic signed [15:0] fqw, logic [1:0] fv,
                                             logic [30:0] dt);
        t_pose_item it;
        it.ref_x = rx;   it.ref_y = ry;   it.ref_qz = rqz;  it.ref_qw = rqw;
        it.ref_ok = rv;  it.meas_x = fx;  it.meas_y = fy;   it.meas_qz = fqz;
        it.meas_qw = fqw; it.meas_ok = fv; it.step_dt = dt;
        return it;
    endfunction

    // ---------------- tests ----------------
    task automatic test_field_extremes();
        send_pose(make_pose(0, 0, 0, 0, 3'b111, 0, 0, 0, 0, 2'b11, 6554));
        send_pose(make_pose(32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sh7FFF, 16'sh7FFF, 3'b111,
                            32'sh80000000, 32'sh80000000, 16'sh8000, 16'sh8000, 2'b11,
                            31'h7FFFFFFF));
        send_pose(make_pose(32'sh80000000, 32'sh80000000, 16'sh8000, 16'sh7FFF, 3'b111,
                            32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sh7FFF, 16'sh8000, 2'b11, 0));
        send_pose(make_pose(65536, -65536, 16384, 0, 3'b111, 0, 0, 0, 16384, 2'b11, 1));
        send_pose(make_pose(0, 0, 0, -16384, 3'b111, 0, 0, 0, -16384, 2'b11, 655));
    endtask

    task automatic test_special_cases();
        // zero quaternion on both poses
        send_pose(make_pose(1000, 2000, 0, 0, 3'b111, 0, 0, 0, 0, 2'b11, 3000));
        // clear valid bits: held values and feed-forward terms stay
        send_pose(make_pose(99999, -99999, 1234, 5678, 3'b000, 777, 888, 100, 16000,
                            2'b00, 6554));
        send_pose(make_pose(131072, 0, 0, 16384, 3'b001, 4000, 0, 0, 16384, 2'b01, 6554));
        send_pose(make_pose(0, 196608, 0, 16384, 3'b010, 0, 5000, 0, 16384, 2'b10, 6554));
        send_pose(make_pose(0, 0, 11585, 11585, 3'b100, 0, 0, 0, 16384, 2'b00, 6554));
        // yaw jump across +-pi, short time step
        send_pose(make_pose(0, 0, 16384, 1, 3'b100, 0, 0, 16384, 1, 2'b11, 1));
        send_pose(make_pose(0, 0, 16384, -1, 3'b100, 0, 0, 16384, -1, 2'b11, 0));
        send_pose(make_pose(0, 0, -16384, 1, 3'b100, 0, 0, -16384, -1, 2'b11, 10));
    endtask

    task automatic test_divisor_zero();
        wait_idle();
        write_all_regs(131072, 131072, 0, 0, 0, 0);
        send_pose(make_pose(65536, 65536, 0, 16384, 3'b111, 0, 0, 5000, 16000, 2'b11, 0));
        send_pose(make_pose(-65536, 65536, 8000, 14000, 3'b111, 100, -100, 0, 16384,
                            2'b11, 1));
        send_pose(rand_pose());
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) send_pose(rand_pose());
    endtask

    task automatic test_register_sweep();
        // extremes first, then random settings over part of each register's range
        wait_idle();
        write_all_regs(6553600, 6553600, 131072, 262144, 65536, 65536);
        run_random(200);
        wait_idle();
        write_all_regs(0, 0, 1, 1, 1, 1);
        run_random(200);
        wait_idle();
        write_all_regs(32'h7FFFFF, 32'h7FFFFF, 32'h3FFFF, 32'h7FFFF, 32'h1FFFF, 32'h1FFFF);
        run_random(150);
        for (int p = 0; p < 4; p++) begin
            wait_idle();
            write_all_regs($urandom_range(0, 6553600), $urandom_range(0, 6553600),
                           $urandom_range(1, 131072), $urandom_range(1, 262144),
                           $urandom_range(1, 65536), $urandom_range(1, 65536));
            run_random(160);
        end
        wait_idle();
        write_all_regs(131072, 131072, 6554, 10486, 2163, 6554);
        run_random(320);
    endtask

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_wheel_cmd exp_cmd;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cmd_queue.size() == 0) begin
                $display("%0t unexpected result %h", $time, m_axis_tdata);
                n_errors++;
            end else begin
                exp_cmd = cmd_queue.pop_front();
                if (m_axis_tdata[31:0] !== exp_cmd.left) begin
                    $display("%0t left_wheel_rate exp %0d got %0d", $time, exp_cmd.left,
                             $signed(m_axis_tdata[31:0]));
                    n_errors++;
                end
                if (m_axis_tdata[63:32] !== exp_cmd.right) begin
                    $display("%0t right_wheel_rate exp %0d got %0d", $time, exp_cmd.right,
                             $signed(m_axis_tdata[63:32]));
                    n_errors++;
                end
                if (m_axis_tdata[95:64] !== exp_cmd.body) begin
                    $display("%0t body_angular_rate exp %0d got %0d", $time, exp_cmd.body,
                             $signed(m_axis_tdata[95:64]));
                    n_errors++;
                end
            end
        end
    end

    // receiver stall pattern: switch at random among four modes
    initial begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(50, 400);
            end
            left--;
            case (mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= $urandom_range(0, 1);
                2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
                default: m_axis_tready <= ((left & 15) < 4);
            endcase
        end
    end

    // watchdog on transfers
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        n_errors      = 0;
        burst_left    = 0;
        idle_cycles   = 0;
        gain_x_r = 131072; gain_y_r = 131072; offset_r = 6554;
        track_r  = 10486;  radius_r = 2163;   min_dt_r = 6554;
        ref_x_h = 0; ref_y_h = 0; ref_yaw_h = 0; ff_w = 0;
        ff_vx = 0; ff_vy = 0; meas_x_h = 0; meas_y_h = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_field_extremes();
        test_special_cases();
        test_divisor_zero();
        test_register_sweep();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
